>>> rtl/target_velocity_track_table_macros.svh
// Assertion macros used by the checker of the track table.
`ifndef TARGET_VELOCITY_TRACK_TABLE_MACROS_SVH
`define TARGET_VELOCITY_TRACK_TABLE_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define TVTT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define TVTT_ASSERT_NEXT(label, ante, cons, msg) \
  `TVTT_ASSERT(label, (ante) |=> (cons), msg)

`endif

>>> rtl/tvtt_pkg.sv
// Shared constants, types and codes of the target velocity track table.
package tvtt_pkg;

  localparam int NUM_TARGETS = 64;
  localparam int ADDR_W      = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
  localparam int ID_W        = 6;
  localparam int TIME_WIDTH  = 32;
  localparam int POS_W       = 24;
  localparam int VEL_W       = 32;
  localparam int TPS_W       = 32;
  localparam int MAG_W       = POS_W + 1;
  localparam int PROD_W      = MAG_W + TPS_W;
  localparam int CNT_W       = $clog2(PROD_W);
  localparam int STATUS_W    = 3;
  localparam int IN_DATA_W   = 88;
  localparam int OUT_DATA_W  = 144;

  localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(1000000);

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_FIRST      = 3'd0,
    ST_UPDATED    = 3'd1,
    ST_REJECT     = 3'd2,
    ST_RANGE      = 3'd3,
    ST_READ_OK    = 3'd4,
    ST_READ_EMPTY = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_READ,
    FSM_EVAL,
    FSM_MUL,
    FSM_DIV,
    FSM_WRITE,
    FSM_DONE
  } fsm_e;

  typedef struct packed {
    logic [TIME_WIDTH-1:0]   tstamp;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_x;
  } entry_t;

  typedef struct packed {
    logic load_in;
    logic eval;
    logic div_start;
    logic div_step;
    logic wr_upd;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_free;
  } dp_stat_t;

endpackage

>>> rtl/target_velocity_track_table.sv
// Top level of the target velocity track table.
// Flow: a report that updates velocity goes through read, evaluate, multiply, the divide
// steps, write and load; every other item goes from evaluate straight to load.
// One item at a time: no new beat is taken until the last result is loaded for output.
// Reset clears all entry valid bits at once and loads ticks_per_second with 1000000.
module target_velocity_track_table (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tvtt_pkg::TPS_W-1:0]       cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: target_id[5:0], pos_x[29:6], pos_y[53:30], timestamp[85:54], zero pad
  input  logic [tvtt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // tuser: cmd
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: out_pos_x[23:0], out_pos_y[47:24], vel_x[79:48], vel_y[111:80], out_time[143:112]
  output logic [tvtt_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // tuser: status
  output logic [tvtt_pkg::STATUS_W-1:0]    m_axis_tuser
);
  import tvtt_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  status_e   out_status;
  entry_t    out_entry;

  // Sequencer: takes one beat, walks it through the datapath, hands it to the output.
  tvtt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Unpack the input beat straight into the datapath capture registers.
  tvtt_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_cmd_i     (s_axis_tuser),
    .in_id_i      (s_axis_tdata[5:0]),
    .in_pos_x_i   (s_axis_tdata[29:6]),
    .in_pos_y_i   (s_axis_tdata[53:30]),
    .in_time_i    (s_axis_tdata[85:54]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_entry_o  (out_entry)
  );

  // Pack the result beat, first field lowest.
  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {out_entry.tstamp, out_entry.vel_y, out_entry.vel_x,
                         out_entry.pos_y, out_entry.pos_x};

endmodule

>>> rtl/tvtt_div.sv
// Restoring divider, one quotient bit per step, with signed saturation.
module tvtt_div (
  input  logic                                 clk_i,
  input  logic                                 start_i,
  input  logic                                 step_i,
  input  logic [tvtt_pkg::PROD_W-1:0]          dividend_i,
  input  logic [tvtt_pkg::TIME_WIDTH-1:0]      divisor_i,
  input  logic                                 neg_i,
  output logic signed [tvtt_pkg::VEL_W-1:0]    quo_o
);
  import tvtt_pkg::*;

  logic [PROD_W-1:0]     dvd_q, dvd_d;
  logic [TIME_WIDTH-1:0] rem_q, rem_d;
  logic [TIME_WIDTH:0]   trial;
  logic                  ge;

  always_comb begin
    trial = {rem_q, dvd_q[PROD_W-1]};
    ge    = trial >= {1'b0, divisor_i};
    rem_d = ge ? TIME_WIDTH'(trial - {1'b0, divisor_i}) : trial[TIME_WIDTH-1:0];
    dvd_d = {dvd_q[PROD_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (step_i) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  // Clamp the magnitude into signed range, then apply the sign.
  always_comb begin
    if (neg_i) begin
      if (dvd_q > PROD_W'(64'h8000_0000)) begin
        quo_o = {1'b1, {(VEL_W-1){1'b0}}};
      end else begin
        quo_o = -$signed(dvd_q[VEL_W-1:0]);
      end
    end else begin
      if (dvd_q > PROD_W'(64'h7FFF_FFFF)) begin
        quo_o = {1'b0, {(VEL_W-1){1'b1}}};
      end else begin
        quo_o = $signed(dvd_q[VEL_W-1:0]);
      end
    end
  end

endmodule

>>> rtl/tvtt_ctrl.sv
// Track table sequencer: one item at a time; read, divide and write if needed.
module tvtt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tvtt_pkg::dp_stat_t    stat_i,
  output tvtt_pkg::ctrl_cmd_t   cmd_o
);
  import tvtt_pkg::*;

  fsm_e             state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             last_step;

  assign last_step = cnt_q == CNT_W'(PROD_W - 1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE:  if (in_valid_i) state_d = FSM_READ;
      FSM_READ:  state_d = FSM_EVAL;
      FSM_EVAL:  state_d = stat_i.need_div ? FSM_MUL : FSM_DONE;
      FSM_MUL:   state_d = FSM_DIV;
      FSM_DIV:   if (last_step) state_d = FSM_WRITE;
      FSM_WRITE: state_d = FSM_DONE;
      FSM_DONE:  if (stat_i.out_free) state_d = FSM_IDLE;
      default:   state_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    cnt_d      = cnt_q;
    unique case (state_q)
      FSM_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      FSM_EVAL:  cmd_o.eval = 1'b1;
      FSM_MUL: begin
        cmd_o.div_start = 1'b1;
        cnt_d           = '0;
      end
      FSM_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CNT_W'(1);
      end
      FSM_WRITE: cmd_o.wr_upd = 1'b1;
      FSM_DONE:  cmd_o.out_load = stat_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> rtl/tvtt_dp.sv
// Datapath of the track table: entry memory, valid bits, multipliers, dividers, output beat.
module tvtt_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tvtt_pkg::ctrl_cmd_t                 cmd_i,
  output tvtt_pkg::dp_stat_t                  stat_o,
  input  logic                                cfg_we_i,
  input  logic [tvtt_pkg::TPS_W-1:0]          cfg_wdata_i,
  input  logic                                in_cmd_i,
  input  logic [tvtt_pkg::ID_W-1:0]           in_id_i,
  input  logic signed [tvtt_pkg::POS_W-1:0]   in_pos_x_i,
  input  logic signed [tvtt_pkg::POS_W-1:0]   in_pos_y_i,
  input  logic [tvtt_pkg::TIME_WIDTH-1:0]     in_time_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output tvtt_pkg::status_e                   out_status_o,
  output tvtt_pkg::entry_t                    out_entry_o
);
  import tvtt_pkg::*;

  logic                    cmd_q;
  logic [ID_W-1:0]         id_q;
  logic signed [POS_W-1:0] px_q, py_q;
  logic [TIME_WIDTH-1:0]   ts_q;
  logic [TPS_W-1:0]        tps_q;
  logic [NUM_TARGETS-1:0]  valid_q;
  entry_t                  mem [NUM_TARGETS];
  entry_t                  rd_q, res_q, wdata;
  logic                    we;
  status_e                 status_q, status_c;
  logic [ADDR_W-1:0]       addr;
  logic                    in_range, hit, delta_ok;
  logic [TIME_WIDTH-1:0]   delta, delta_q;
  logic signed [MAG_W-1:0] dx, dy;
  logic [MAG_W-1:0]        mag_x_q, mag_y_q;
  logic                    neg_x_q, neg_y_q;
  logic [PROD_W-1:0]       prod_x, prod_y;
  logic signed [VEL_W-1:0] quo_x, quo_y;
  logic                    out_valid_q;

  assign addr     = id_q[ADDR_W-1:0];
  assign in_range = (ID_W + 1)'(id_q) < (ID_W + 1)'(NUM_TARGETS);
  assign hit      = valid_q[addr];
  assign delta    = ts_q - rd_q.tstamp;
  assign delta_ok = (delta != '0) && !delta[TIME_WIDTH-1];
  assign dx       = MAG_W'(px_q) - MAG_W'(rd_q.pos_x);
  assign dy       = MAG_W'(py_q) - MAG_W'(rd_q.pos_y);

  always_comb begin
    if (!in_range) begin
      status_c = ST_RANGE;
    end else if (cmd_q == CMD_READ) begin
      status_c = hit ? ST_READ_OK : ST_READ_EMPTY;
    end else if (!hit) begin
      status_c = ST_FIRST;
    end else begin
      status_c = delta_ok ? ST_UPDATED : ST_REJECT;
    end
  end

  assign stat_o.need_div = status_c == ST_UPDATED;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= TPS_RESET;
    end else if (cfg_we_i) begin
      tps_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cmd_q <= in_cmd_i;
      id_q  <= in_id_i;
      px_q  <= in_pos_x_i;
      py_q  <= in_pos_y_i;
      ts_q  <= in_time_i;
    end
  end

  // New entry for a first report, else the reported position and time with fresh velocity.
  always_comb begin
    wdata = res_q;
    we    = 1'b0;
    if (cmd_i.eval && status_c == ST_FIRST) begin
      wdata.pos_x  = px_q;
      wdata.pos_y  = py_q;
      wdata.vel_x  = '0;
      wdata.vel_y  = '0;
      wdata.tstamp = ts_q;
      we           = 1'b1;
    end else if (cmd_i.wr_upd) begin
      wdata.vel_x = quo_x;
      wdata.vel_y = quo_y;
      we          = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[addr];
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we) begin
      valid_q[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      status_q <= status_c;
      mag_x_q  <= dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
      mag_y_q  <= dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
      neg_x_q  <= dx[MAG_W-1];
      neg_y_q  <= dy[MAG_W-1];
      delta_q  <= delta;
      case (status_c)
        ST_RANGE, ST_READ_EMPTY: res_q <= '0;
        ST_FIRST: res_q <= wdata;
        ST_UPDATED: begin
          res_q        <= rd_q;
          res_q.pos_x  <= px_q;
          res_q.pos_y  <= py_q;
          res_q.tstamp <= ts_q;
        end
        default: res_q <= rd_q;
      endcase
    end else if (cmd_i.wr_upd) begin
      res_q <= wdata;
    end
  end

  assign prod_x = PROD_W'(mag_x_q) * PROD_W'(tps_q);
  assign prod_y = PROD_W'(mag_y_q) * PROD_W'(tps_q);

  tvtt_div u_div_x (
    .clk_i      (clk_i),
    .start_i    (cmd_i.div_start),
    .step_i     (cmd_i.div_step),
    .dividend_i (prod_x),
    .divisor_i  (delta_q),
    .neg_i      (neg_x_q),
    .quo_o      (quo_x)
  );

  tvtt_div u_div_y (
    .clk_i      (clk_i),
    .start_i    (cmd_i.div_start),
    .step_i     (cmd_i.div_step),
    .dividend_i (prod_y),
    .divisor_i  (delta_q),
    .neg_i      (neg_y_q),
    .quo_o      (quo_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_o <= status_q;
      out_entry_o  <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/tvtt_checker.sv
// Port-level checker of the track table, bound to the top level.
`include "target_velocity_track_table_macros.svh"

module tvtt_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [tvtt_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic [tvtt_pkg::STATUS_W-1:0]    m_axis_tuser
);
  import tvtt_pkg::*;

  `TVTT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "output beat changed while stalled")
  `TVTT_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second beat taken while busy")
  `TVTT_ASSERT(a_empty_zero, m_axis_tvalid && (m_axis_tuser == ST_READ_EMPTY || m_axis_tuser == ST_RANGE) |-> m_axis_tdata == '0, "empty result carries data")
  `TVTT_ASSERT(a_first_zero_vel, m_axis_tvalid && m_axis_tuser == ST_FIRST |-> m_axis_tdata[111:48] == '0, "first report with nonzero velocity")

endmodule

bind target_velocity_track_table tvtt_checker u_tvtt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
